/* sv/spg_pkg.sv */
// shared types, sizes and sine table for the sine plasma pixel generator
package spg_pkg;

   localparam int COLUMNS = 128;
   localparam int ROWS    = 128;

   localparam int COL_W   = 7;
   localparam int ROW_W   = 7;
   localparam int TICK_W  = 9;
   localparam int COLOR_W = 16;

   localparam int          SINE_W     = 9;
   localparam int          ANGLE_W    = 8;
   localparam logic [7:0]  GREEN_OFS  = 8'd85;
   localparam logic [7:0]  BLUE_OFS   = 8'd170;

   typedef logic signed [SINE_W-1:0] sine_type;
   typedef sine_type [255:0]         table_type;

   // control that travels down the pipeline with each item
   typedef struct packed {
      logic                 valid;
      logic                 outside;
      logic [ANGLE_W-1:0]   pa;
      logic [ANGLE_W-1:0]   pb;
      logic [ANGLE_W-1:0]   pc;
   } ctl_type;

   // quarter wave from a q15 oscillator, then mirrored into a full period
   function automatic table_type build_sine();
      table_type          t;
      logic signed [31:0] s;
      logic signed [31:0] c;
      logic signed [31:0] ns;
      logic signed [31:0] nc;
      logic signed [31:0] prod;
      sine_type           v;
      logic [7:0]         idx;
      int                 i;
      t = '0;
      s = 32'sd0;
      c = 32'sd32767;
      for (i = 0; i <= 64; i++) begin
         prod = s * 32'sd255;
         t[8'(i)] = SINE_W'(prod >>> 15);
         prod = c * 32'sd804;
         ns = s + (prod >>> 15);
         prod = ns * 32'sd804;
         nc = c - (prod >>> 15);
         s = ns;
         c = nc;
      end
      t[8'd64] = 9'sd255;
      for (i = 0; i <= 64; i++) begin
         v = t[8'(i)];
         idx = 8'(128 - i);
         t[idx] = v;
         idx = 8'(128 + i);
         t[idx] = -v;
         idx = 8'(256 - i);
         t[idx] = -v;
      end
      return t;
   endfunction

   localparam table_type SINE_TABLE = build_sine();

endpackage

/* sv/spg_field.sv */
// plasma field: three coordinate sines, their sum and the truncated third
module spg_field (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [spg_pkg::COL_W-1:0]    in_column,
   input  logic [spg_pkg::ROW_W-1:0]    in_row,
   input  logic [spg_pkg::TICK_W-1:0]   in_tick,
   output spg_pkg::ctl_type             out_ctl,
   output logic [spg_pkg::ANGLE_W-1:0]  out_q
);

   spg_pkg::ctl_type  ctl1_in, ctl1_ff, ctl2_ff;
   spg_pkg::sine_type sx_in, sy_in, sd_in;
   spg_pkg::sine_type sx_ff, sy_ff, sd_ff;
   logic [spg_pkg::ANGLE_W-1:0] q_in, q_ff;

   logic [10:0] tick3;
   logic [7:0]  ax, ay, ad;
   logic [7:0]  sum_cr;
   logic signed [10:0] v;
   logic [9:0]  mag;
   logic [18:0] prod;
   logic [7:0]  quo;

   // stage one: phases and the three field sines
   always_comb begin
      tick3            = 11'(in_tick) + {1'b0, in_tick, 1'b0};
      ctl1_in.valid    = in_valid;
      ctl1_in.outside  = (32'(in_column) >= spg_pkg::COLUMNS) ||
                         (32'(in_row) >= spg_pkg::ROWS);
      ctl1_in.pa       = in_tick[7:0];
      ctl1_in.pb       = tick3[8:1];
      ctl1_in.pc       = in_tick[8:1];
      sum_cr           = 8'(in_column) + 8'(in_row);
      ax               = {in_column[5:0], 2'b00} + ctl1_in.pa;
      ay               = {in_row[5:0], 2'b00} + ctl1_in.pb;
      ad               = sum_cr + {sum_cr[6:0], 1'b0} + ctl1_in.pc;
      sx_in            = spg_pkg::SINE_TABLE[ax];
      sy_in            = spg_pkg::SINE_TABLE[ay];
      sd_in            = spg_pkg::SINE_TABLE[ad];
   end

   // stage two: sum and divide by three toward zero (683 / 2048 reciprocal)
   always_comb begin
      v    = 11'(sx_ff) + 11'(sy_ff) + 11'(sd_ff);
      mag  = v[10] ? 10'(-v) : 10'(v);
      prod = 19'(mag) * 19'd683;
      quo  = prod[18:11];
      q_in = v[10] ? 8'(-quo) : quo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid <= 1'b0;
         ctl2_ff.valid <= 1'b0;
      end else begin
         ctl1_ff.valid <= ctl1_in.valid;
         ctl2_ff.valid <= ctl1_ff.valid;
      end
      ctl1_ff.outside <= ctl1_in.outside;
      ctl1_ff.pa      <= ctl1_in.pa;
      ctl1_ff.pb      <= ctl1_in.pb;
      ctl1_ff.pc      <= ctl1_in.pc;
      ctl2_ff.outside <= ctl1_ff.outside;
      ctl2_ff.pa      <= ctl1_ff.pa;
      ctl2_ff.pb      <= ctl1_ff.pb;
      ctl2_ff.pc      <= ctl1_ff.pc;
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      sd_ff <= sd_in;
      q_ff  <= q_in;
   end

   assign out_ctl = ctl2_ff;
   assign out_q   = q_ff;

endmodule

/* sv/spg_color.sv */
// color stage: three phase-shifted sines of the field value, clamp and rgb565 pack
module spg_color (
   input  logic                          clock,
   input  logic                          reset,
   input  spg_pkg::ctl_type              in_ctl,
   input  logic [spg_pkg::ANGLE_W-1:0]   in_q,
   output logic                          out_strobe,
   output logic [spg_pkg::COLOR_W-1:0]   out_color
);

   logic                         strobe_in, strobe_ff;
   logic [spg_pkg::COLOR_W-1:0]  color_in, color_ff;
   logic [7:0]                   ar, ag, ab;
   logic [7:0]                   r, g, b;

   function automatic logic [7:0] level(input spg_pkg::sine_type s);
      logic signed [9:0] t;
      t = 10'sd128 + 10'(s >>> 1);
      if (t < 10'sd0) begin
         return 8'd0;
      end else if (t > 10'sd255) begin
         return 8'd255;
      end
      return t[7:0];
   endfunction

   always_comb begin
      ar        = in_q + in_ctl.pa;
      ag        = in_q + spg_pkg::GREEN_OFS + in_ctl.pc;
      ab        = in_q + spg_pkg::BLUE_OFS + in_ctl.pb;
      r         = level(spg_pkg::SINE_TABLE[ar]);
      g         = level(spg_pkg::SINE_TABLE[ag]);
      b         = level(spg_pkg::SINE_TABLE[ab]);
      strobe_in = in_ctl.valid;
      if (in_ctl.outside) begin
         color_in = '0;
      end else begin
         color_in = {r[7:3], g[7:2], b[7:3]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
      color_ff <= color_in;
   end

   assign out_strobe = strobe_ff;
   assign out_color  = color_ff;

endmodule

/* sv/sine_plasma_pixel_generator_top.sv */
// top level of the sine plasma pixel generator
// a result strobes once its item has passed the input register, the
//   field sine register, the field quotient register and the color register
// throughput: one item per cycle; busy is high only during reset
// reset: synchronous, active high; clears the pipeline valid bits, items in flight are dropped
// the receiver cannot stall, so results leave in the cycle they are finished
module sine_plasma_pixel_generator_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_start,
   output logic                          req_busy,
   input  logic [spg_pkg::COL_W-1:0]     req_column,
   input  logic [spg_pkg::ROW_W-1:0]     req_row,
   input  logic [spg_pkg::TICK_W-1:0]    req_tick,
   output logic                          rsp_strobe,
   output logic [spg_pkg::COLOR_W-1:0]   rsp_color
);

   logic                          valid_in, valid_ff;
   logic [spg_pkg::COL_W-1:0]     column_ff;
   logic [spg_pkg::ROW_W-1:0]     row_ff;
   logic [spg_pkg::TICK_W-1:0]    tick_ff;
   spg_pkg::ctl_type              field_ctl;
   logic [spg_pkg::ANGLE_W-1:0]   field_q;

   assign req_busy = reset;
   assign valid_in = req_start && !req_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      column_ff <= req_column;
      row_ff    <= req_row;
      tick_ff   <= req_tick;
   end

   spg_field u_field (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_ff),
      .in_column (column_ff),
      .in_row    (row_ff),
      .in_tick   (tick_ff),
      .out_ctl   (field_ctl),
      .out_q     (field_q)
   );

   spg_color u_color (
      .clock      (clock),
      .reset      (reset),
      .in_ctl     (field_ctl),
      .in_q       (field_q),
      .out_strobe (rsp_strobe),
      .out_color  (rsp_color)
   );

   // every accepted item comes out after the input, field sine, field quotient and color registers
   assert property (@(posedge clock) disable iff (reset)
      (req_start && !req_busy) |-> ##4 rsp_strobe)
      else $error("accepted item did not produce a result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_start && !req_busy, 4))
      else $error("result without a matching item");

   // a valid item at the field stage output is followed by the output strobe in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      field_ctl.valid |=> rsp_strobe)
      else $error("field stage item lost before the color stage");

endmodule
